// ----- sv/rei_pkg.sv -----
// shared types and constants of the rotary encoder event queue
package rei_pkg;

  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned CODE_W    = 2;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX      = '1;
  localparam logic [ELAPSED_W-1:0] ROTARY_WIN_RESET = 16'd20;
  localparam logic [ELAPSED_W-1:0] BUTTON_WIN_RESET = 16'd50;
  localparam logic [COUNT_W-1:0]   COUNT_MAX        = 4'd15;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_ROTARY = 2'd1;
  localparam logic [1:0] FUNC_BUTTON = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic [CODE_W-1:0] EV_CW    = 2'd0;
  localparam logic [CODE_W-1:0] EV_CCW   = 2'd1;
  localparam logic [CODE_W-1:0] EV_CLICK = 2'd2;

  localparam logic REG_ROTARY_WIN = 1'b0;
  localparam logic REG_BUTTON_WIN = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic       line_one_level;
    logic       line_two_level;
  } in_beat_t;

  typedef struct packed {
    logic              read_valid;
    logic [CODE_W-1:0] event_code;
    logic              empty_flag;
    logic              dropped;
    logic [COUNT_W-1:0] queued_count;
  } out_beat_t;

  typedef struct packed {
    logic shift;
    logic push;
  } cell_ctl_t;

endpackage

// ----- sv/rei_in_if.sv -----
// input channel of the rotary encoder event queue
interface rei_in_if;
  logic             valid;
  logic             ready;
  rei_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rei_out_if.sv -----
// result channel of the rotary encoder event queue
interface rei_out_if;
  logic              valid;
  logic              ready;
  rei_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rei_cell.sv -----
// one slot of the shifting event queue
module rei_cell #(
  parameter int unsigned CNT_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  logic                       clk_i,
  input  rei_pkg::cell_ctl_t         ctl_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic [rei_pkg::CODE_W-1:0] new_code_i,
  input  logic [rei_pkg::CODE_W-1:0] next_code_i,
  output logic [rei_pkg::CODE_W-1:0] code_o
);

  logic [rei_pkg::CODE_W-1:0] code_q;
  logic [rei_pkg::CODE_W-1:0] code_d;

  always_comb begin
    code_d = code_q;
    if (ctl_i.shift) begin
      code_d = next_code_i;
    end else if (ctl_i.push && (count_i == CNT_W'(IDX))) begin
      code_d = new_code_i;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign code_o = code_q;

endmodule

// ----- sv/rotary_encoder_event_queue.sv -----
// top level: debounce, decode and a shifting cell queue of encoder events
// One beat is taken per clock cycle and its result appears in the output
// register on the next cycle; the input stalls only while that register holds
// a result the sink has not taken. Events sit in a row of QUEUE_SLOTS-1 cells:
// a push loads the first free cell, a read takes the head cell and every cell
// takes its neighbor's event in the same cycle. queued_count saturates at 15.
// Both debounce windows are APB registers at byte addresses 0 and 4.
module rotary_encoder_event_queue #(
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rei_in_if.sink                       in_i,
  rei_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rei_pkg::PADDR_W-1:0]  paddr,
  input  logic [rei_pkg::APB_W-1:0]    pwdata,
  output logic [rei_pkg::APB_W-1:0]    prdata,
  output logic                         pready
);

  localparam int unsigned CELLS = QUEUE_SLOTS - 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_SLOTS);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_SLOTS - 1);

  logic [rei_pkg::ELAPSED_W-1:0] rot_win_q, btn_win_q;
  logic [rei_pkg::ELAPSED_W-1:0] rot_el_q, rot_el_d, btn_el_q, btn_el_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic                          out_valid_q;
  rei_pkg::out_beat_t            out_q, out_d;

  logic                          in_ready, accept, wr_en;
  logic                          push, pop, full;
  logic [rei_pkg::CODE_W-1:0]    new_code;
  logic [31:0]                   cnt_ext;
  rei_pkg::cell_ctl_t            ctl;
  logic [rei_pkg::CODE_W-1:0]    chain [CELLS+1];

  // apb register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_win_q <= rei_pkg::ROTARY_WIN_RESET;
      btn_win_q <= rei_pkg::BUTTON_WIN_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        rei_pkg::REG_ROTARY_WIN: rot_win_q <= pwdata[rei_pkg::ELAPSED_W-1:0];
        rei_pkg::REG_BUTTON_WIN: btn_win_q <= pwdata[rei_pkg::ELAPSED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rei_pkg::REG_ROTARY_WIN: prdata = {16'd0, rot_win_q};
      rei_pkg::REG_BUTTON_WIN: prdata = {16'd0, btn_win_q};
      default:                 prdata = '0;
    endcase
  end

  // handshake
  assign in_ready    = !out_valid_q || out_o.ready;
  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // debounce, decode and queue control
  assign full = (count_q == FULL_CNT);

  always_comb begin
    rot_el_d = rot_el_q;
    btn_el_d = btn_el_q;
    push     = 1'b0;
    pop      = 1'b0;
    new_code = rei_pkg::EV_CLICK;
    out_d    = '0;
    unique case (in_i.data.func)
      rei_pkg::FUNC_TICK: begin
        if (rot_el_q != rei_pkg::ELAPSED_MAX) rot_el_d = rot_el_q + 1'b1;
        if (btn_el_q != rei_pkg::ELAPSED_MAX) btn_el_d = btn_el_q + 1'b1;
      end
      rei_pkg::FUNC_ROTARY: begin
        if (rot_el_q >= rot_win_q) begin
          rot_el_d = '0;
          if (!in_i.data.line_one_level) begin
            new_code = in_i.data.line_two_level ? rei_pkg::EV_CW : rei_pkg::EV_CCW;
            push          = !full;
            out_d.dropped = full;
          end
        end
      end
      rei_pkg::FUNC_BUTTON: begin
        if (btn_el_q >= btn_win_q) begin
          btn_el_d      = '0;
          push          = !full;
          out_d.dropped = full;
        end
      end
      rei_pkg::FUNC_READ: begin
        if (count_q == '0) begin
          out_d.empty_flag = 1'b1;
        end else begin
          pop              = 1'b1;
          out_d.read_valid = 1'b1;
          out_d.event_code = chain[0];
        end
      end
      default: ;
    endcase

    count_d = count_q;
    if (push) count_d = count_q + 1'b1;
    if (pop)  count_d = count_q - 1'b1;
    cnt_ext = 32'(count_d);
    out_d.queued_count = (cnt_ext > 32'(rei_pkg::COUNT_MAX)) ? rei_pkg::COUNT_MAX
                                                             : cnt_ext[3:0];
  end

  assign ctl.shift = accept && pop;
  assign ctl.push  = accept && push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_el_q    <= rei_pkg::ELAPSED_MAX;
      btn_el_q    <= rei_pkg::ELAPSED_MAX;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rot_el_q <= rot_el_d;
        btn_el_q <= btn_el_d;
        count_q  <= count_d;
      end
      if (in_ready) out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  // queue cells
  assign chain[CELLS] = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    rei_cell #(
      .CNT_W (CNT_W),
      .IDX   (k)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .new_code_i  (new_code),
      .next_code_i (chain[k+1]),
      .code_o      (chain[k])
    );
  end

endmodule

// ----- sv/rei_checker.sv -----
// port level checks of the rotary encoder event queue and their bind
module rei_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       read_valid_i,
  input logic [rei_pkg::CODE_W-1:0] event_code_i,
  input logic                       empty_flag_i,
  input logic                       dropped_i
);

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_code_i)
      && $stable(read_valid_i))
    else $error("result beat changed while stalled");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

  // a read either pops or reports empty, never both, and a drop comes with neither
  a_read_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(read_valid_i && empty_flag_i)
      && !(dropped_i && (read_valid_i || empty_flag_i)))
    else $error("conflicting result flags");

  // no event code without a popped event
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !read_valid_i |-> event_code_i == rei_pkg::EV_CW)
    else $error("event code set without a pop");

  // an accepted beat always yields a result beat
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted beat gave no result");

endmodule

bind rotary_encoder_event_queue rei_checker u_rei_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .read_valid_i (out_o.data.read_valid),
  .event_code_i (out_o.data.event_code),
  .empty_flag_i (out_o.data.empty_flag),
  .dropped_i    (out_o.data.dropped)
);

// ----- dv/tb_rotary_encoder_event_queue.sv -----
// testbench of the rotary encoder event queue: directed and random beats checked by a predictor
`timescale 1ns / 1ps

module tb_rotary_encoder_event_queue;

  localparam int unsigned QUEUE_SLOTS = 16;
  localparam int unsigned PHASE_BEATS = 180;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned WIDE_TICKS  = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rei_pkg::PADDR_W-1:0]  paddr;
  logic [rei_pkg::APB_W-1:0]    pwdata;
  logic [rei_pkg::APB_W-1:0]    prdata;
  logic                         pready;

  rei_in_if  in_if ();
  rei_out_if out_if ();

  rotary_encoder_event_queue #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // encoder state as the block should hold it
  logic [rei_pkg::ELAPSED_W-1:0] rot_window;
  logic [rei_pkg::ELAPSED_W-1:0] btn_window;
  logic [rei_pkg::ELAPSED_W-1:0] rot_elapsed;
  logic [rei_pkg::ELAPSED_W-1:0] btn_elapsed;
  logic [rei_pkg::CODE_W-1:0]    decoded_events[$];

  rei_pkg::in_beat_t    beats_to_send[$];
  rei_pkg::out_beat_t   expected_results[$];
  rei_pkg::out_beat_t   oldest_result;
  logic                 in_beat_fired;
  int unsigned          src_idle_pct;
  int unsigned          snk_idle_pct;
  int unsigned          fail_count;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic queue_event(logic [rei_pkg::CODE_W-1:0] code);
    if (decoded_events.size() >= QUEUE_SLOTS - 1) begin
      return 1'b1;
    end
    decoded_events.push_back(code);
    return 1'b0;
  endfunction

  function automatic rei_pkg::out_beat_t predict_result(rei_pkg::in_beat_t b);
    rei_pkg::out_beat_t r;
    r = '0;
    case (b.func)
      rei_pkg::FUNC_TICK: begin
        if (rot_elapsed != rei_pkg::ELAPSED_MAX) rot_elapsed = rot_elapsed + 1'b1;
        if (btn_elapsed != rei_pkg::ELAPSED_MAX) btn_elapsed = btn_elapsed + 1'b1;
      end
      rei_pkg::FUNC_ROTARY: begin
        if (rot_elapsed >= rot_window) begin
          rot_elapsed = '0;
          if (!b.line_one_level) begin
            r.dropped = queue_event(b.line_two_level ? rei_pkg::EV_CW : rei_pkg::EV_CCW);
          end
        end
      end
      rei_pkg::FUNC_BUTTON: begin
        if (btn_elapsed >= btn_window) begin
          btn_elapsed = '0;
          r.dropped = queue_event(rei_pkg::EV_CLICK);
        end
      end
      rei_pkg::FUNC_READ: begin
        if (decoded_events.size() == 0) begin
          r.empty_flag = 1'b1;
        end else begin
          r.read_valid = 1'b1;
          r.event_code = decoded_events.pop_front();
        end
      end
      default: ;
    endcase
    r.queued_count = (decoded_events.size() > rei_pkg::COUNT_MAX)
                     ? rei_pkg::COUNT_MAX
                     : rei_pkg::COUNT_W'(decoded_events.size());
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // driver: new beat after each accepted one, with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_beat_fired) begin
        if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data  <= beats_to_send.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // monitor: predict on accepted input beats, check accepted result beats
  always @(posedge clk_i) begin
    in_beat_fired <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      expected_results.push_back(predict_result(in_if.data));
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("read_valid", oldest_result.read_valid, out_if.data.read_valid);
        check_field("event_code", oldest_result.event_code, out_if.data.event_code);
        check_field("empty_flag", oldest_result.empty_flag, out_if.data.empty_flag);
        check_field("dropped", oldest_result.dropped, out_if.data.dropped);
        check_field("queued_count", oldest_result.queued_count, out_if.data.queued_count);
      end
    end
  end

  task automatic add_beat(input logic [1:0] func, input logic l1, input logic l2);
    rei_pkg::in_beat_t b;
    b.func           = func;
    b.line_one_level = l1;
    b.line_two_level = l2;
    beats_to_send.push_back(b);
  endtask

  task automatic wait_drained();
    while (beats_to_send.size() != 0 || in_if.valid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic apb_access(input logic wr, input logic reg_idx, input logic [15:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= rei_pkg::APB_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!wr && prdata !== rei_pkg::APB_W'(value)) begin
      $error("window register %0d: expected %0d, got %0d", reg_idx, value, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_windows(input logic [15:0] rot, input logic [15:0] btn);
    wait_drained();
    apb_access(1'b1, rei_pkg::REG_ROTARY_WIN, rot);
    apb_access(1'b1, rei_pkg::REG_BUTTON_WIN, btn);
    rot_window = rot;
    btn_window = btn;
    apb_access(1'b0, rei_pkg::REG_ROTARY_WIN, rot);
    apb_access(1'b0, rei_pkg::REG_BUTTON_WIN, btn);
  endtask

  task automatic add_random_beats(input int unsigned n, input int unsigned edge_pct,
                                  input int unsigned burst_max);
    int unsigned added;
    int unsigned r;
    int unsigned k;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        k = $urandom_range(1, burst_max);
        repeat (k) begin
          add_beat(rei_pkg::FUNC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        added += k;
      end else if (r < 20 + edge_pct) begin
        if ($urandom_range(0, 1)) begin
          add_beat(rei_pkg::FUNC_ROTARY, 1'($urandom_range(0, 3) == 0),
                   1'($urandom_range(0, 1)));
        end else begin
          add_beat(rei_pkg::FUNC_BUTTON, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        added++;
      end else begin
        add_beat(rei_pkg::FUNC_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        added++;
      end
    end
  endtask

  // two halves with a full drain in between
  task automatic run_phase(input logic [15:0] rot, input logic [15:0] btn,
                           input int unsigned edge_pct, input int unsigned burst_max);
    set_windows(rot, btn);
    add_random_beats(PHASE_BEATS / 2, edge_pct, burst_max);
    wait_drained();
    add_random_beats(PHASE_BEATS / 2, edge_pct, burst_max);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_beat_fired = 1'b0;
    fail_count   = 0;
    rot_window   = rei_pkg::ROTARY_WIN_RESET;
    btn_window   = rei_pkg::BUTTON_WIN_RESET;
    rot_elapsed  = rei_pkg::ELAPSED_MAX;
    btn_elapsed  = rei_pkg::ELAPSED_MAX;
    src_idle_pct = 23;
    snk_idle_pct = 50;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values of the window registers
    apb_access(1'b0, rei_pkg::REG_ROTARY_WIN, rei_pkg::ROTARY_WIN_RESET);
    apb_access(1'b0, rei_pkg::REG_BUTTON_WIN, rei_pkg::BUTTON_WIN_RESET);

    // reset windows, counters saturated and held there by a tick
    add_beat(rei_pkg::FUNC_TICK, 1'b0, 1'b0);
    add_beat(rei_pkg::FUNC_READ, 1'b0, 1'b0);
    add_beat(rei_pkg::FUNC_ROTARY, 1'b0, 1'b1);
    add_beat(rei_pkg::FUNC_ROTARY, 1'b0, 1'b0);
    add_beat(rei_pkg::FUNC_BUTTON, 1'b0, 1'b0);
    add_beat(rei_pkg::FUNC_BUTTON, 1'b1, 1'b1);
    add_beat(rei_pkg::FUNC_TICK, 1'b1, 1'b1);
    add_beat(rei_pkg::FUNC_READ, 1'b1, 1'b1);

    // zero windows: line one high, both directions, fill to full and drop
    set_windows(16'd0, 16'd0);
    add_beat(rei_pkg::FUNC_ROTARY, 1'b1, 1'b1);
    add_beat(rei_pkg::FUNC_ROTARY, 1'b1, 1'b0);
    add_beat(rei_pkg::FUNC_ROTARY, 1'b0, 1'b0);
    repeat (QUEUE_SLOTS - 3) add_beat(rei_pkg::FUNC_BUTTON, 1'b0, 1'b0);
    add_beat(rei_pkg::FUNC_BUTTON, 1'b0, 1'b0);
    add_beat(rei_pkg::FUNC_ROTARY, 1'b0, 1'b1);
    add_beat(rei_pkg::FUNC_READ, 1'b0, 1'b0);

    run_phase(16'd3, 16'd7, 55, 10);
    run_phase(16'd0, 16'd0, 75, 3);

    wait_drained();
    src_idle_pct = 50;
    snk_idle_pct = 23;
    run_phase(16'd1, 16'd0, 35, 4);
    run_phase(16'd20, 16'd50, 45, 60);

    wait_drained();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    // widest windows reject edges that follow soon after the last one
    set_windows(16'd0, 16'd0);
    add_beat(rei_pkg::FUNC_ROTARY, 1'b1, 1'b0);
    add_beat(rei_pkg::FUNC_BUTTON, 1'b0, 1'b1);
    set_windows(16'hFFFF, 16'hFFFF);
    repeat (WIDE_TICKS) add_beat(rei_pkg::FUNC_TICK, 1'b0, 1'b0);
    add_beat(rei_pkg::FUNC_ROTARY, 1'b0, 1'b1);
    add_beat(rei_pkg::FUNC_BUTTON, 1'b0, 1'b0);
    add_beat(rei_pkg::FUNC_TICK, 1'b0, 1'b1);
    add_beat(rei_pkg::FUNC_TICK, 1'b1, 1'b0);
    add_beat(rei_pkg::FUNC_ROTARY, 1'b0, 1'b0);
    add_beat(rei_pkg::FUNC_BUTTON, 1'b0, 1'b0);
    add_beat(rei_pkg::FUNC_READ, 1'b0, 1'b0);

    run_phase(16'd0, 16'hFFFF, 60, 5);
    run_phase(16'd2, 16'd1, 65, 4);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
